// ===== hdl/kmst_pkg.sv =====
// Shared types and constants of the minimum spanning tree engine.
package kmst_pkg;

    localparam int VERTEX_BITS = 6;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int MAX_RESULTS = 63;
    localparam int RESULT_CNT_BITS = 6;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clear;
    } sort_ctl_t;

    typedef struct packed {
        logic init;
        logic merge;
    } vtx_ctl_t;

endpackage

// ===== hdl/kruskal_mst_engine.sv =====
// Top level of the minimum spanning tree engine: edge store, vertex sets and run sequencer.
//
//   channel  direction  payload
//   s_       in         edge_u, edge_v, edge_weight, holds_edge, last_edge
//   m_       out        tree_u, tree_v, tree_weight, no_tree_edge, edges_dropped, last_of_tree
//
// Edges load at one item per cycle, while the load state lasts, into a chain of sorting cells
// that keeps them in order. After the last item, each stored edge is fetched, then evaluated,
// until the store is empty or 63 tree edges are found; a last fetch finds the store empty or
// the limit reached, and a finishing step delivers the final item.
// A stalled result channel holds the run in the evaluate or finishing step.
// Reset is synchronous and active low; the sets and store clear after each run.
module kruskal_mst_engine #(
    parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = kmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    s_edge_u,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    s_edge_v,
    input  logic signed [WEIGHT_BITS-1:0]       s_edge_weight,
    input  logic                                s_holds_edge,
    input  logic                                s_last_edge,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kmst_pkg::VERTEX_BITS-1:0]    m_tree_u,
    output logic [kmst_pkg::VERTEX_BITS-1:0]    m_tree_v,
    output logic signed [WEIGHT_BITS-1:0]       m_tree_weight,
    output logic                                m_no_tree_edge,
    output logic                                m_edges_dropped,
    output logic                                m_last_of_tree
);

    localparam int VB = kmst_pkg::VERTEX_BITS;
    localparam int NV = (MAX_VERTICES < (1 << VB)) ? MAX_VERTICES : (1 << VB);
    localparam int LW = (NV > 1) ? $clog2(NV) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int RB = kmst_pkg::RESULT_CNT_BITS;

    typedef enum logic [1:0] {ST_LOAD, ST_FETCH, ST_EVAL, ST_FLUSH} state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [RB-1:0]          found_reg;
    logic                   ovf_reg;
    logic                   pend_valid_reg;
    logic [VB-1:0]          pend_u_reg;
    logic [VB-1:0]          pend_v_reg;
    logic [WEIGHT_BITS-1:0] pend_w_reg;
    logic [VB-1:0]          e_u_reg;
    logic [VB-1:0]          e_v_reg;
    logic [WEIGHT_BITS-1:0] e_w_reg;
    logic                   e_ok_reg;
    logic [LW-1:0]          lu_reg;
    logic [LW-1:0]          lv_reg;
    logic                   m_valid_reg;
    logic [VB-1:0]          m_u_reg;
    logic [VB-1:0]          m_v_reg;
    logic [WEIGHT_BITS-1:0] m_w_reg;
    logic                   m_none_reg;
    logic                   m_drop_reg;
    logic                   m_last_reg;

    logic                   c_valid [MAX_EDGES];
    logic [VB-1:0]          c_u     [MAX_EDGES];
    logic [VB-1:0]          c_v     [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] c_w     [MAX_EDGES];
    logic                   c_le    [MAX_EDGES];
    logic [LW-1:0]          hu      [NV];
    logic [LW-1:0]          hv      [NV];
    logic [LW-1:0]          lu_any;
    logic [LW-1:0]          lv_any;

    kmst_pkg::sort_ctl_t    sctl;
    kmst_pkg::vtx_ctl_t     vctl;
    logic                   accept;
    logic                   out_free;
    logic                   is_tree;
    logic                   proceed;
    logic                   head_go;
    logic                   emit;

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_tree  = e_ok_reg && (lu_reg != lv_reg);
    assign proceed  = !is_tree || !pend_valid_reg || out_free;
    assign head_go  = c_valid[0] && (found_reg < RB'(kmst_pkg::MAX_RESULTS));
    assign emit     = ((state_reg == ST_EVAL) && proceed && is_tree && pend_valid_reg) ||
                      ((state_reg == ST_FLUSH) && out_free);

    assign sctl.ins   = accept && s_holds_edge && (count_reg < CW'(MAX_EDGES));
    assign sctl.pop   = (state_reg == ST_FETCH) && head_go;
    assign sctl.clear = (state_reg == ST_FLUSH) && out_free;
    assign vctl.init  = sctl.clear;
    assign vctl.merge = (state_reg == ST_EVAL) && is_tree && proceed;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EDGES; gi++) begin : g_sort
            logic                   l_le;
            logic                   l_valid;
            logic [VB-1:0]          l_u;
            logic [VB-1:0]          l_v;
            logic [WEIGHT_BITS-1:0] l_w;
            logic                   r_valid;
            logic [VB-1:0]          r_u;
            logic [VB-1:0]          r_v;
            logic [WEIGHT_BITS-1:0] r_w;
            if (gi == 0) begin : g_first
                assign l_le    = 1'b1;
                assign l_valid = 1'b0;
                assign l_u     = '0;
                assign l_v     = '0;
                assign l_w     = '0;
            end else begin : g_mid
                assign l_le    = c_le[gi-1] || !c_valid[gi-1] ? c_le[gi-1] : 1'b0;
                assign l_valid = c_valid[gi-1];
                assign l_u     = c_u[gi-1];
                assign l_v     = c_v[gi-1];
                assign l_w     = c_w[gi-1];
            end
            if (gi == MAX_EDGES - 1) begin : g_last
                assign r_valid = 1'b0;
                assign r_u     = '0;
                assign r_v     = '0;
                assign r_w     = '0;
            end else begin : g_body
                assign r_valid = c_valid[gi+1];
                assign r_u     = c_u[gi+1];
                assign r_v     = c_v[gi+1];
                assign r_w     = c_w[gi+1];
            end
            kmst_sort_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (sctl),
                .key_u       (s_edge_u),
                .key_v       (s_edge_v),
                .key_w       (s_edge_weight),
                .left_le     (l_le),
                .left_valid  (l_valid),
                .left_u      (l_u),
                .left_v      (l_v),
                .left_w      (l_w),
                .right_valid (r_valid),
                .right_u     (r_u),
                .right_v     (r_v),
                .right_w     (r_w),
                .own_le      (c_le[gi]),
                .valid_reg   (c_valid[gi]),
                .u_reg       (c_u[gi]),
                .v_reg       (c_v[gi]),
                .w_reg       (c_w[gi])
            );
        end

        for (gi = 0; gi < NV; gi++) begin : g_vtx
            kmst_vertex_cell #(.IDX(gi), .LW(LW)) u_vtx (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (vctl),
                .look_u    (c_u[0]),
                .look_v    (c_v[0]),
                .new_label (lu_reg),
                .old_label (lv_reg),
                .hit_u     (hu[gi]),
                .hit_v     (hv[gi])
            );
        end
    endgenerate

    always_comb begin
        lu_any = '0;
        lv_any = '0;
        for (int k = 0; k < NV; k++) begin
            lu_any = lu_any | hu[k];
            lv_any = lv_any | hv[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            found_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (s_holds_edge) begin
                            if (count_reg < CW'(MAX_EDGES)) begin
                                count_reg <= count_reg + CW'(1);
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        if (s_last_edge) begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    if (head_go) begin
                        e_u_reg   <= c_u[0];
                        e_v_reg   <= c_v[0];
                        e_w_reg   <= c_w[0];
                        e_ok_reg  <= (32'(c_u[0]) < 32'(NV)) && (32'(c_v[0]) < 32'(NV));
                        lu_reg    <= lu_any;
                        lv_reg    <= lv_any;
                        count_reg <= count_reg - CW'(1);
                        state_reg <= ST_EVAL;
                    end else begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_EVAL: begin
                    if (proceed) begin
                        if (is_tree) begin
                            if (pend_valid_reg) begin
                                m_valid_reg <= 1'b1;
                                m_u_reg     <= pend_u_reg;
                                m_v_reg     <= pend_v_reg;
                                m_w_reg     <= pend_w_reg;
                                m_none_reg  <= 1'b0;
                                m_drop_reg  <= ovf_reg;
                                m_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_u_reg     <= e_u_reg;
                            pend_v_reg     <= e_v_reg;
                            pend_w_reg     <= e_w_reg;
                            found_reg      <= found_reg + RB'(1);
                        end
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_u_reg        <= pend_valid_reg ? pend_u_reg : '0;
                        m_v_reg        <= pend_valid_reg ? pend_v_reg : '0;
                        m_w_reg        <= pend_valid_reg ? pend_w_reg : '0;
                        m_none_reg     <= !pend_valid_reg;
                        m_drop_reg     <= ovf_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        found_reg      <= '0;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tree_u        = m_u_reg;
    assign m_tree_v        = m_v_reg;
    assign m_tree_weight   = m_w_reg;
    assign m_no_tree_edge  = m_none_reg;
    assign m_edges_dropped = m_drop_reg;
    assign m_last_of_tree  = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_EDGES))
        else $error("The stored edge count exceeds the store depth.");
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_none_reg |-> m_last_reg)
        else $error("An empty tree item is not marked as the final item.");
    a_no_self_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_none_reg |-> m_u_reg != m_v_reg)
        else $error("A self-loop was emitted as a tree edge.");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> !pend_valid_reg && found_reg == '0)
        else $error("Run state remains while loading edges.");
`endif

endmodule

// ===== hdl/kmst_sort_cell.sv =====
// One cell of the insertion sorting chain that holds a single stored edge.
module kmst_sort_cell #(
    parameter int WEIGHT_BITS = kmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kmst_pkg::sort_ctl_t                 ctl,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    key_u,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    key_v,
    input  logic signed [WEIGHT_BITS-1:0]       key_w,
    input  logic                                left_le,
    input  logic                                left_valid,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    left_u,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    left_v,
    input  logic signed [WEIGHT_BITS-1:0]       left_w,
    input  logic                                right_valid,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    right_u,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    right_v,
    input  logic signed [WEIGHT_BITS-1:0]       right_w,
    output logic                                own_le,
    output logic                                valid_reg,
    output logic [kmst_pkg::VERTEX_BITS-1:0]    u_reg,
    output logic [kmst_pkg::VERTEX_BITS-1:0]    v_reg,
    output logic signed [WEIGHT_BITS-1:0]       w_reg
);

    assign own_le = valid_reg && (w_reg <= key_w);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctl.ins) begin
            if (!own_le) begin
                if (left_le) begin
                    valid_reg <= 1'b1;
                    u_reg     <= key_u;
                    v_reg     <= key_v;
                    w_reg     <= key_w;
                end else begin
                    valid_reg <= left_valid;
                    u_reg     <= left_u;
                    v_reg     <= left_v;
                    w_reg     <= left_w;
                end
            end
        end else if (ctl.pop) begin
            valid_reg <= right_valid;
            u_reg     <= right_u;
            v_reg     <= right_v;
            w_reg     <= right_w;
        end
    end

endmodule

// ===== hdl/kmst_vertex_cell.sv =====
// One vertex cell holding the set label of its vertex.
module kmst_vertex_cell #(
    parameter int IDX = 0,
    parameter int LW  = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kmst_pkg::vtx_ctl_t                  ctl,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    look_u,
    input  logic [kmst_pkg::VERTEX_BITS-1:0]    look_v,
    input  logic [LW-1:0]                       new_label,
    input  logic [LW-1:0]                       old_label,
    output logic [LW-1:0]                       hit_u,
    output logic [LW-1:0]                       hit_v
);

    logic [LW-1:0] label_reg;

    assign hit_u = (look_u == kmst_pkg::VERTEX_BITS'(IDX)) ? label_reg : '0;
    assign hit_v = (look_v == kmst_pkg::VERTEX_BITS'(IDX)) ? label_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.init) begin
            label_reg <= LW'(IDX);
        end else if (ctl.merge && (label_reg == old_label)) begin
            label_reg <= new_label;
        end
    end

endmodule
